/* sv/http_request_head_parser_macros.svh */
// Assertion macros for the port-level checks of the request head parser.
// Each macro expects aclk and aresetn to be in scope where it is used.
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("request head parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("request head parser check failed");

`endif

/* sv/hrhp_pkg.sv */
// Package for the request head parser: parser states, status codes, result flags
// and the byte class functions. No dependencies.
package hrhp_pkg;

    localparam int VERSION_WIDTH_DEF = 8;
    localparam int TDATA_IN_W        = 8;
    localparam int TDATA_OUT_W       = 32;
    localparam int VER_OUT_W         = 8;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CTL_MAX  = 8'd31;

    typedef enum logic [4:0] {
        ST_METHOD_START,
        ST_METHOD,
        ST_HPATH_START,
        ST_HPATH,
        ST_URI,
        ST_VER_H,
        ST_VER_T1,
        ST_VER_T2,
        ST_VER_P,
        ST_VER_SLASH,
        ST_MAJ_START,
        ST_MAJ,
        ST_MIN_START,
        ST_MIN,
        ST_NL1,
        ST_LINE_START,
        ST_LWS,
        ST_NAME,
        ST_SP_BEFORE_VAL,
        ST_VALUE,
        ST_NL2,
        ST_NL3
    } parse_state_t;

    typedef enum logic [1:0] {
        RES_MORE = 2'd0,
        RES_GOOD = 2'd1,
        RES_BAD  = 2'd2
    } res_t;

    // Status sits in the lowest bits so that the struct packs straight into tdata.
    typedef struct packed {
        logic to_header_value;
        logic to_header_name;
        logic header_begin;
        logic to_file_path;
        logic to_uri;
        logic to_handler_path;
        logic to_method;
        res_t status;
    } result_t;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CTL_MAX) || (c == CH_DEL);
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
            8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_separator(c);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* sv/hrhp_step.sv */
// Next-state and result logic of the request head parser for one byte.
// Depends on hrhp_pkg.
module hrhp_step
    import hrhp_pkg::*;
#(
    parameter int VERSION_WIDTH = VERSION_WIDTH_DEF
) (
    input  parse_state_t             state_cur,
    input  logic                     header_seen_cur,
    input  logic [VERSION_WIDTH-1:0] maj_cur,
    input  logic [VERSION_WIDTH-1:0] min_cur,
    input  logic [7:0]               data_byte,
    input  logic                     restart,
    output parse_state_t             state_nxt,
    output logic                     header_seen_nxt,
    output logic [VERSION_WIDTH-1:0] maj_nxt,
    output logic [VERSION_WIDTH-1:0] min_nxt,
    output result_t                  res
);

    localparam int PW = VERSION_WIDTH + 4;
    localparam logic [PW-1:0] LIM = {4'b0, {VERSION_WIDTH{1'b1}}};

    logic [3:0]               digit;
    logic [PW-1:0]            maj_sum;
    logic [PW-1:0]            min_sum;
    logic [VERSION_WIDTH-1:0] maj_acc;
    logic [VERSION_WIDTH-1:0] min_acc;

    assign digit   = 4'(data_byte - CH_ZERO);
    assign maj_sum = ({4'b0, maj_cur} << 3) + ({4'b0, maj_cur} << 1) + PW'(digit);
    assign min_sum = ({4'b0, min_cur} << 3) + ({4'b0, min_cur} << 1) + PW'(digit);
    assign maj_acc = (maj_sum > LIM) ? {VERSION_WIDTH{1'b1}} : maj_sum[VERSION_WIDTH-1:0];
    assign min_acc = (min_sum > LIM) ? {VERSION_WIDTH{1'b1}} : min_sum[VERSION_WIDTH-1:0];

    always_comb begin
        state_nxt       = state_cur;
        header_seen_nxt = header_seen_cur;
        maj_nxt         = maj_cur;
        min_nxt         = min_cur;
        res             = '0;
        res.status      = RES_MORE;
        if (restart) begin
            state_nxt       = ST_METHOD_START;
            header_seen_nxt = 1'b0;
            maj_nxt         = '0;
            min_nxt         = '0;
        end else begin
            case (state_cur)
                ST_METHOD_START: begin
                    if (is_token(data_byte)) begin
                        state_nxt     = ST_METHOD;
                        res.to_method = 1'b1;
                    end else res.status = RES_BAD;
                end
                ST_METHOD: begin
                    if (data_byte == CH_SP) state_nxt = ST_HPATH_START;
                    else if (is_token(data_byte)) res.to_method = 1'b1;
                    else res.status = RES_BAD;
                end
                ST_HPATH_START: begin
                    if (data_byte == CH_SLASH) begin
                        state_nxt           = ST_HPATH;
                        res.to_handler_path = 1'b1;
                        res.to_uri          = 1'b1;
                    end else res.status = RES_BAD;
                end
                ST_HPATH: begin
                    if (data_byte == CH_SP) state_nxt = ST_VER_H;
                    else if (is_ctl(data_byte)) res.status = RES_BAD;
                    else if (data_byte == CH_SLASH) begin
                        state_nxt        = ST_URI;
                        res.to_file_path = 1'b1;
                        res.to_uri       = 1'b1;
                    end else begin
                        res.to_handler_path = 1'b1;
                        res.to_uri          = 1'b1;
                    end
                end
                ST_URI: begin
                    if (data_byte == CH_SP) state_nxt = ST_VER_H;
                    else if (is_ctl(data_byte)) res.status = RES_BAD;
                    else begin
                        res.to_uri       = 1'b1;
                        res.to_file_path = 1'b1;
                    end
                end
                ST_VER_H: begin
                    if (data_byte == CH_H) state_nxt = ST_VER_T1;
                    else res.status = RES_BAD;
                end
                ST_VER_T1: begin
                    if (data_byte == CH_T) state_nxt = ST_VER_T2;
                    else res.status = RES_BAD;
                end
                ST_VER_T2: begin
                    if (data_byte == CH_T) state_nxt = ST_VER_P;
                    else res.status = RES_BAD;
                end
                ST_VER_P: begin
                    if (data_byte == CH_P) state_nxt = ST_VER_SLASH;
                    else res.status = RES_BAD;
                end
                ST_VER_SLASH: begin
                    if (data_byte == CH_SLASH) begin
                        maj_nxt   = '0;
                        min_nxt   = '0;
                        state_nxt = ST_MAJ_START;
                    end else res.status = RES_BAD;
                end
                ST_MAJ_START: begin
                    if (is_dec_digit(data_byte)) begin
                        maj_nxt   = maj_acc;
                        state_nxt = ST_MAJ;
                    end else res.status = RES_BAD;
                end
                ST_MAJ: begin
                    if (data_byte == CH_DOT) state_nxt = ST_MIN_START;
                    else if (is_dec_digit(data_byte)) maj_nxt = maj_acc;
                    else res.status = RES_BAD;
                end
                ST_MIN_START: begin
                    if (is_dec_digit(data_byte)) begin
                        min_nxt   = min_acc;
                        state_nxt = ST_MIN;
                    end else res.status = RES_BAD;
                end
                ST_MIN: begin
                    if (data_byte == CH_CR) state_nxt = ST_NL1;
                    else if (is_dec_digit(data_byte)) min_nxt = min_acc;
                    else res.status = RES_BAD;
                end
                ST_NL1: begin
                    if (data_byte == CH_LF) state_nxt = ST_LINE_START;
                    else res.status = RES_BAD;
                end
                ST_LINE_START: begin
                    if (data_byte == CH_CR) state_nxt = ST_NL3;
                    else if (header_seen_cur && (data_byte == CH_SP || data_byte == CH_HT)) begin
                        state_nxt = ST_LWS;
                    end else if (is_token(data_byte)) begin
                        header_seen_nxt    = 1'b1;
                        res.header_begin   = 1'b1;
                        res.to_header_name = 1'b1;
                        state_nxt          = ST_NAME;
                    end else res.status = RES_BAD;
                end
                ST_LWS: begin
                    if (data_byte == CH_CR) state_nxt = ST_NL2;
                    else if (data_byte == CH_SP || data_byte == CH_HT) state_nxt = ST_LWS;
                    else if (is_ctl(data_byte)) res.status = RES_BAD;
                    else begin
                        state_nxt           = ST_VALUE;
                        res.to_header_value = 1'b1;
                    end
                end
                ST_NAME: begin
                    if (data_byte == CH_COLON) state_nxt = ST_SP_BEFORE_VAL;
                    else if (is_token(data_byte)) res.to_header_name = 1'b1;
                    else res.status = RES_BAD;
                end
                ST_SP_BEFORE_VAL: begin
                    if (data_byte == CH_SP) state_nxt = ST_VALUE;
                    else res.status = RES_BAD;
                end
                ST_VALUE: begin
                    if (data_byte == CH_CR) state_nxt = ST_NL2;
                    else if (is_ctl(data_byte)) res.status = RES_BAD;
                    else res.to_header_value = 1'b1;
                end
                ST_NL2: begin
                    if (data_byte == CH_LF) state_nxt = ST_LINE_START;
                    else res.status = RES_BAD;
                end
                ST_NL3: begin
                    res.status = (data_byte == CH_LF) ? RES_GOOD : RES_BAD;
                end
                default: begin
                    res.status = RES_BAD;
                end
            endcase
        end
    end

endmodule

/* sv/http_request_head_parser.sv */
// Top level of the HTTP/1.x request head parser: input register, parser state
// and result register. Depends on hrhp_pkg and hrhp_step.
//
//  Channel | Role   | tdata (low bit first)                       | tuser
//  s_      | bytes  | data_byte[7:0]                              | restart
//  m_      | result | status, seven field flags, major, minor     | none
//
// Each byte passes through the input register, then through the parser step into the
// result register.
// One byte is accepted in every cycle while the result side keeps up.
// A stall on m_tready holds both registers; with the input register full,
// s_tready drops in the same cycle.
// Reset returns the parser to the method start with both versions at zero.
module http_request_head_parser
    import hrhp_pkg::*;
#(
    parameter int VERSION_WIDTH = VERSION_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] status, [2] to_method, [3] to_handler_path, [4] to_uri,
    // [5] to_file_path, [6] header_begin, [7] to_header_name,
    // [8] to_header_value, [16:9] major_version, [24:17] minor_version, rest zero
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int RES_W = $bits(result_t);
    localparam int PAD_W = TDATA_OUT_W - RES_W - 2 * VER_OUT_W;

    logic                     in_vld_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_restart_reg;
    parse_state_t             state_reg;
    parse_state_t             state_next;
    logic                     header_seen_reg;
    logic                     header_seen_next;
    logic [VERSION_WIDTH-1:0] maj_reg;
    logic [VERSION_WIDTH-1:0] maj_next;
    logic [VERSION_WIDTH-1:0] min_reg;
    logic [VERSION_WIDTH-1:0] min_next;
    result_t                  res;
    logic [VER_OUT_W-1:0]     maj_out;
    logic [VER_OUT_W-1:0]     min_out;
    logic                     out_vld_reg;
    result_t                  out_res_reg;
    logic [VER_OUT_W-1:0]     out_maj_reg;
    logic [VER_OUT_W-1:0]     out_min_reg;
    logic                     advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    hrhp_step #(
        .VERSION_WIDTH(VERSION_WIDTH)
    ) u_step (
        .state_cur      (state_reg),
        .header_seen_cur(header_seen_reg),
        .maj_cur        (maj_reg),
        .min_cur        (min_reg),
        .data_byte      (in_byte_reg),
        .restart        (in_restart_reg),
        .state_nxt      (state_next),
        .header_seen_nxt(header_seen_next),
        .maj_nxt        (maj_next),
        .min_nxt        (min_next),
        .res            (res)
    );

    generate
        if (VERSION_WIDTH >= VER_OUT_W) begin : g_ver_trunc
            assign maj_out = maj_next[VER_OUT_W-1:0];
            assign min_out = min_next[VER_OUT_W-1:0];
        end else begin : g_ver_ext
            assign maj_out = {{(VER_OUT_W - VERSION_WIDTH){1'b0}}, maj_next};
            assign min_out = {{(VER_OUT_W - VERSION_WIDTH){1'b0}}, min_next};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            state_reg       <= ST_METHOD_START;
            header_seen_reg <= 1'b0;
            maj_reg         <= '0;
            min_reg         <= '0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg     <= 1'b1;
                state_reg       <= state_next;
                header_seen_reg <= header_seen_next;
                maj_reg         <= maj_next;
                min_reg         <= min_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata[7:0];
            in_restart_reg <= s_tuser;
        end
        if (advance) begin
            out_res_reg <= res;
            out_maj_reg <= maj_out;
            out_min_reg <= min_out;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_min_reg, out_maj_reg, out_res_reg};

endmodule

/* sv/hrhp_checker.sv */
// Port-level checks on the request head parser, bound to the top level.
// Depends on hrhp_pkg and http_request_head_parser_macros.svh.
`include "http_request_head_parser_macros.svh"

module hrhp_checker
    import hrhp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [TDATA_IN_W-1:0]  s_tdata,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // A rejected byte never claims to join any request field.
    `HRHP_ASSERT_NOW(a_bad_no_flags, m_tvalid && m_tdata[1:0] == RES_BAD, m_tdata[8:2] == 7'd0)

    // A completed head is reported only on its final newline, with no field flags.
    `HRHP_ASSERT_NOW(a_good_no_flags, m_tvalid && m_tdata[1:0] == RES_GOOD, m_tdata[8:2] == 7'd0)

    // A new header entry always starts its name with the same byte.
    `HRHP_ASSERT_NOW(a_begin_has_name, m_tvalid && m_tdata[6], m_tdata[7] && !m_tdata[2])

    // A result that is not taken stays on the bus unchanged.
    `HRHP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (.*);

/* tb/tb_http_request_head_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_request_head_parser: a directed request, then random
// request heads with noise, checked transfer by transfer. Depends on hrhp_pkg and the RTL.
module tb_http_request_head_parser;
    import hrhp_pkg::*;

    localparam int RES_W        = 25;
    localparam int HEAD_N       = 33;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_PCT     = 18;
    localparam int BURST_FROM   = 300;
    localparam int BURST_TO     = 700;
    localparam int DRAIN_AT     = 1000;
    localparam int HOLD_AT      = 1400;
    localparam int HOLD_LEN     = 300;
    localparam int LIMIT        = 200000;
    localparam int unsigned VER_MAX = (1 << VER_OUT_W) - 1;

    typedef struct packed {
        logic             restart;
        logic [7:0]       data;
        logic             fixed;
        logic [RES_W-1:0] want;
    } feed_item_t;

    localparam logic [RES_W:0] NO_FIX = '0;
    localparam logic [6:0]     NOFLAGS = 7'd0;

    // The fixed rows give {minor, major, flags, status} where they are plain to see.
    localparam feed_item_t HEAD_ROWS [HEAD_N] = '{
        {1'b1, 8'h00, 1'b1, {8'd0, 8'd0, NOFLAGS, RES_MORE}},
        {1'b0, 8'hFF, 1'b1, {8'd0, 8'd0, NOFLAGS, RES_BAD}},
        {1'b0, "G", NO_FIX},
        {1'b0, CH_SP, NO_FIX},
        {1'b0, CH_SLASH, NO_FIX},
        {1'b0, 8'hFF, NO_FIX},
        {1'b0, CH_SLASH, NO_FIX},
        {1'b0, 8'h80, NO_FIX},
        {1'b0, CH_SP, NO_FIX},
        {1'b0, CH_H, NO_FIX},
        {1'b0, CH_T, NO_FIX},
        {1'b0, CH_T, NO_FIX},
        {1'b0, CH_P, NO_FIX},
        {1'b0, CH_SLASH, NO_FIX},
        {1'b0, "9", NO_FIX},
        {1'b0, "9", NO_FIX},
        {1'b0, "9", 1'b1, {8'd0, 8'd255, NOFLAGS, RES_MORE}},
        {1'b0, CH_DOT, NO_FIX},
        {1'b0, "1", NO_FIX},
        {1'b0, CH_CR, NO_FIX},
        {1'b0, CH_LF, NO_FIX},
        // A continuation line is refused before any header has begun.
        {1'b0, CH_SP, 1'b1, {8'd1, 8'd255, NOFLAGS, RES_BAD}},
        {1'b0, "x", NO_FIX},
        {1'b0, CH_COLON, NO_FIX},
        {1'b0, CH_SP, NO_FIX},
        {1'b0, CH_CR, NO_FIX},
        {1'b0, CH_LF, NO_FIX},
        {1'b0, CH_HT, NO_FIX},
        {1'b0, CH_CR, NO_FIX},
        {1'b0, CH_LF, NO_FIX},
        {1'b0, CH_CR, NO_FIX},
        {1'b0, CH_LF, 1'b1, {8'd1, 8'd255, NOFLAGS, RES_GOOD}},
        {1'b0, CH_LF, 1'b1, {8'd1, 8'd255, NOFLAGS, RES_GOOD}}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    feed_item_t       feed [$];
    logic [RES_W-1:0] parse_results_due [$];
    int               errors = 0;
    int               cycle_count = 0;
    bit               burst = 1'b0;
    bit               hold_go = 1'b0;
    bit               hold_done = 1'b0;

    parse_state_t         head_state = ST_METHOD_START;
    bit                   hdr_seen = 1'b0;
    logic [VER_OUT_W-1:0] ver_hi = '0;
    logic [VER_OUT_W-1:0] ver_lo = '0;

    http_request_head_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit byte_is_ctl(input logic [7:0] c);
        return (c <= 8'd31) || (c == 8'd127);
    endfunction

    function automatic bit byte_is_sep(input logic [7:0] c);
        bit r;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", " ", "\t": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic bit byte_is_tok(input logic [7:0] c);
        return (c < 8'd128) && !byte_is_ctl(c) && !byte_is_sep(c);
    endfunction

    function automatic bit byte_is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [VER_OUT_W-1:0] ver_step(input logic [VER_OUT_W-1:0] v,
                                                      input logic [7:0] c);
        int unsigned n;
        n = v * 10 + c - "0";
        return (n > VER_MAX) ? VER_MAX[VER_OUT_W-1:0] : n[VER_OUT_W-1:0];
    endfunction

    // Advances the parser copy by one byte and returns {minor, major, flags, status}.
    function automatic logic [RES_W-1:0] parse_byte(input logic rst, input logic [7:0] c);
        result_t      r;
        parse_state_t nx;
        r = '0;
        r.status = RES_MORE;
        nx = head_state;
        if (rst) begin
            head_state = ST_METHOD_START;
            hdr_seen = 1'b0;
            ver_hi = '0;
            ver_lo = '0;
        end else begin
            case (head_state)
                ST_METHOD_START: begin
                    if (byte_is_tok(c)) begin
                        nx = ST_METHOD;
                        r.to_method = 1'b1;
                    end else r.status = RES_BAD;
                end
                ST_METHOD: begin
                    if (c == CH_SP) nx = ST_HPATH_START;
                    else if (byte_is_tok(c)) r.to_method = 1'b1;
                    else r.status = RES_BAD;
                end
                ST_HPATH_START: begin
                    if (c == CH_SLASH) begin
                        nx = ST_HPATH;
                        r.to_handler_path = 1'b1;
                        r.to_uri = 1'b1;
                    end else r.status = RES_BAD;
                end
                ST_HPATH: begin
                    if (c == CH_SP) nx = ST_VER_H;
                    else if (byte_is_ctl(c)) r.status = RES_BAD;
                    else if (c == CH_SLASH) begin
                        nx = ST_URI;
                        r.to_file_path = 1'b1;
                        r.to_uri = 1'b1;
                    end else begin
                        r.to_handler_path = 1'b1;
                        r.to_uri = 1'b1;
                    end
                end
                ST_URI: begin
                    if (c == CH_SP) nx = ST_VER_H;
                    else if (byte_is_ctl(c)) r.status = RES_BAD;
                    else begin
                        r.to_uri = 1'b1;
                        r.to_file_path = 1'b1;
                    end
                end
                ST_VER_H: begin
                    if (c == CH_H) nx = ST_VER_T1;
                    else r.status = RES_BAD;
                end
                ST_VER_T1: begin
                    if (c == CH_T) nx = ST_VER_T2;
                    else r.status = RES_BAD;
                end
                ST_VER_T2: begin
                    if (c == CH_T) nx = ST_VER_P;
                    else r.status = RES_BAD;
                end
                ST_VER_P: begin
                    if (c == CH_P) nx = ST_VER_SLASH;
                    else r.status = RES_BAD;
                end
                ST_VER_SLASH: begin
                    if (c == CH_SLASH) begin
                        ver_hi = '0;
                        ver_lo = '0;
                        nx = ST_MAJ_START;
                    end else r.status = RES_BAD;
                end
                ST_MAJ_START: begin
                    if (byte_is_num(c)) begin
                        ver_hi = ver_step(ver_hi, c);
                        nx = ST_MAJ;
                    end else r.status = RES_BAD;
                end
                ST_MAJ: begin
                    if (c == CH_DOT) nx = ST_MIN_START;
                    else if (byte_is_num(c)) ver_hi = ver_step(ver_hi, c);
                    else r.status = RES_BAD;
                end
                ST_MIN_START: begin
                    if (byte_is_num(c)) begin
                        ver_lo = ver_step(ver_lo, c);
                        nx = ST_MIN;
                    end else r.status = RES_BAD;
                end
                ST_MIN: begin
                    if (c == CH_CR) nx = ST_NL1;
                    else if (byte_is_num(c)) ver_lo = ver_step(ver_lo, c);
                    else r.status = RES_BAD;
                end
                ST_NL1: begin
                    if (c == CH_LF) nx = ST_LINE_START;
                    else r.status = RES_BAD;
                end
                ST_LINE_START: begin
                    if (c == CH_CR) nx = ST_NL3;
                    else if (hdr_seen && (c == CH_SP || c == CH_HT)) nx = ST_LWS;
                    else if (byte_is_tok(c)) begin
                        hdr_seen = 1'b1;
                        r.header_begin = 1'b1;
                        r.to_header_name = 1'b1;
                        nx = ST_NAME;
                    end else r.status = RES_BAD;
                end
                ST_LWS: begin
                    if (c == CH_CR) nx = ST_NL2;
                    else if (c == CH_SP || c == CH_HT) nx = ST_LWS;
                    else if (byte_is_ctl(c)) r.status = RES_BAD;
                    else begin
                        nx = ST_VALUE;
                        r.to_header_value = 1'b1;
                    end
                end
                ST_NAME: begin
                    if (c == CH_COLON) nx = ST_SP_BEFORE_VAL;
                    else if (byte_is_tok(c)) r.to_header_name = 1'b1;
                    else r.status = RES_BAD;
                end
                ST_SP_BEFORE_VAL: begin
                    if (c == CH_SP) nx = ST_VALUE;
                    else r.status = RES_BAD;
                end
                ST_VALUE: begin
                    if (c == CH_CR) nx = ST_NL2;
                    else if (byte_is_ctl(c)) r.status = RES_BAD;
                    else r.to_header_value = 1'b1;
                end
                ST_NL2: begin
                    if (c == CH_LF) nx = ST_LINE_START;
                    else r.status = RES_BAD;
                end
                ST_NL3: begin
                    if (c == CH_LF) r.status = RES_GOOD;
                    else r.status = RES_BAD;
                end
                default: r.status = RES_BAD;
            endcase
            head_state = nx;
        end
        return {ver_lo, ver_hi, r};
    endfunction

    function automatic logic [7:0] rand_tok();
        logic [7:0] c;
        do c = 8'($urandom_range(127)); while (!byte_is_tok(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_text(input bit no_space);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (byte_is_ctl(c) || (no_space && c == CH_SP));
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        logic [7:0] c;
        c = 8'($urandom_range(9));
        return CH_ZERO + c;
    endfunction

    function automatic int digit_count();
        return ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
    endfunction

    // Appends one request head, mostly well formed, sometimes damaged, sometimes pure noise.
    task automatic add_request();
        logic [7:0] req [$];
        logic [7:0] rb;
        logic       rst;
        int         n;
        int         k;
        int         h;
        int         hdrs;
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(4, 24);
            repeat (n) begin
                rb = 8'($urandom_range(255));
                rst = ($urandom_range(7) == 0);
                feed.insert(feed.size(), {rst, rb, NO_FIX});
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) req.insert(req.size(), rand_tok());
            req.insert(req.size(), CH_SP);
            req.insert(req.size(), CH_SLASH);
            n = $urandom_range(0, 6);
            repeat (n) req.insert(req.size(), rand_text(1'b1));
            if ($urandom_range(1) == 1) begin
                req.insert(req.size(), CH_SLASH);
                n = $urandom_range(0, 6);
                repeat (n) req.insert(req.size(), rand_text(1'b1));
            end
            req.insert(req.size(), CH_SP);
            req.insert(req.size(), CH_H);
            req.insert(req.size(), CH_T);
            req.insert(req.size(), CH_T);
            req.insert(req.size(), CH_P);
            req.insert(req.size(), CH_SLASH);
            n = digit_count();
            repeat (n) req.insert(req.size(), rand_digit());
            req.insert(req.size(), CH_DOT);
            n = digit_count();
            repeat (n) req.insert(req.size(), rand_digit());
            req.insert(req.size(), CH_CR);
            req.insert(req.size(), CH_LF);
            hdrs = $urandom_range(0, 4);
            if (hdrs == 0 && $urandom_range(2) == 0) req.insert(req.size(), CH_HT);
            for (h = 0; h < hdrs; h++) begin
                n = $urandom_range(1, 8);
                repeat (n) req.insert(req.size(), rand_tok());
                req.insert(req.size(), CH_COLON);
                req.insert(req.size(), CH_SP);
                n = $urandom_range(0, 8);
                repeat (n) req.insert(req.size(), rand_text(1'b0));
                req.insert(req.size(), CH_CR);
                req.insert(req.size(), CH_LF);
                if ($urandom_range(3) == 0) begin
                    req.insert(req.size(), $urandom_range(1) ? CH_SP : CH_HT);
                    n = $urandom_range(0, 2);
                    repeat (n) req.insert(req.size(), $urandom_range(1) ? CH_SP : CH_HT);
                    n = $urandom_range(0, 5);
                    repeat (n) req.insert(req.size(), rand_text(1'b0));
                    req.insert(req.size(), CH_CR);
                    req.insert(req.size(), CH_LF);
                end
            end
            req.insert(req.size(), CH_CR);
            req.insert(req.size(), CH_LF);
            if ($urandom_range(3) == 0) req.insert(req.size(), CH_LF);
            if ($urandom_range(5) == 0) req.insert(req.size(), rand_text(1'b0));
            if ($urandom_range(99) < 20) begin
                k = $urandom_range(req.size() - 1);
                req[k] = 8'($urandom_range(255));
            end
            if ($urandom_range(99) < 10) begin
                k = $urandom_range(req.size() - 1);
                rb = 8'($urandom_range(255));
                req.insert(k, rb);
            end
            if ($urandom_range(99) < 85) begin
                rb = 8'($urandom_range(255));
                feed.insert(feed.size(), {1'b1, rb, NO_FIX});
            end
            foreach (req[i]) begin
                rst = ($urandom_range(79) == 0);
                feed.insert(feed.size(), {rst, req[i], NO_FIX});
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 200)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void compare_result(input logic [RES_W-1:0] want,
                                           input logic [TDATA_OUT_W-1:0] got);
        result_t w;
        result_t g;
        w = want[8:0];
        g = got[8:0];
        check_field("status", 8'(w.status), 8'(g.status));
        check_field("to_method", 8'(w.to_method), 8'(g.to_method));
        check_field("to_handler_path", 8'(w.to_handler_path), 8'(g.to_handler_path));
        check_field("to_uri", 8'(w.to_uri), 8'(g.to_uri));
        check_field("to_file_path", 8'(w.to_file_path), 8'(g.to_file_path));
        check_field("header_begin", 8'(w.header_begin), 8'(g.header_begin));
        check_field("to_header_name", 8'(w.to_header_name), 8'(g.to_header_name));
        check_field("to_header_value", 8'(w.to_header_value), 8'(g.to_header_value));
        check_field("major_version", want[16:9], got[16:9]);
        check_field("minor_version", want[24:17], got[24:17]);
        check_field("padding", 8'd0, 8'(got[31:25]));
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (parse_results_due.size() == 0) begin
                errors++;
                if (errors <= 200)
                    $display("%0t: result expected none, got %h", $time, m_tdata);
            end else begin
                compare_result(parse_results_due.pop_front(), m_tdata);
            end
        end
    end

    // The long hold-off lets the input side fill up and stall while bytes keep coming.
    initial begin
        int i;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (i = 0; i < HOLD_LEN; i++) @(posedge aclk);
            end else begin
                m_tready <= burst || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int               idx;
        bit               drain;
        logic [RES_W-1:0] word;
        foreach (HEAD_ROWS[i]) feed.insert(feed.size(), HEAD_ROWS[i]);
        while (feed.size() < HEAD_N + RANDOM_ITEMS) add_request();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (idx = 0; idx < feed.size(); idx++) begin
            burst = (idx >= BURST_FROM) && (idx < BURST_TO);
            if (idx == HOLD_AT) hold_go = 1'b1;
            drain = (idx == HEAD_N) || (idx == DRAIN_AT);
            if (drain || (!burst && $urandom_range(99) < IDLE_PCT)) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk);
                while (drain ? parse_results_due.size() != 0 : $urandom_range(99) < IDLE_PCT);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= feed[idx].data;
            s_tuser  <= feed[idx].restart;
            do @(posedge aclk); while (!s_tready);
            word = parse_byte(feed[idx].restart, feed[idx].data);
            if (feed[idx].fixed) word = feed[idx].want;
            parse_results_due.insert(parse_results_due.size(), word);
        end
        burst = 1'b0;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (parse_results_due.size() != 0);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/hrhp_pkg.sv
sv/hrhp_step.sv
sv/http_request_head_parser.sv
sv/hrhp_checker.sv
tb/tb_http_request_head_parser.sv
